// ===== sv/sscpk_pkg.sv =====
// Shared types and constants for the sample statistics / Cpk engine.
package sscpk_pkg;

   localparam int DATA_W     = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int ROOT_IN_W  = 64;
   localparam int ROOT_W     = 32;

   localparam logic [30:0] SAT31 = '1;

   // result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FEW  = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;
   localparam logic [1:0] STATUS_DROP = 2'd3;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_UPPER_LIMIT  = 2'd0;
   localparam logic [1:0] REG_UPPER_ENABLE = 2'd1;
   localparam logic [1:0] REG_LOWER_LIMIT  = 2'd2;
   localparam logic [1:0] REG_LOWER_ENABLE = 2'd3;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [8:0]         count;
      logic signed [31:0] mean;
      logic signed [31:0] median;
      logic [30:0]        sigma;
      logic signed [31:0] cpk;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_SCAN,
      S_MED_MUL,
      S_MED_SEL,
      S_VAR_GO,
      S_VAR_WAIT,
      S_ROOT_GO,
      S_ROOT_WAIT,
      S_STAT,
      S_UP_GO,
      S_UP_WAIT,
      S_LO_GO,
      S_LO_WAIT,
      S_FINISH
   } state_type;

endpackage

// ===== sv/sscpk_cell.sv =====
// One cell of the sorting chain: holds one sample, inserts or shifts toward the head.
module sscpk_cell import sscpk_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = 9
) (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic [CNT_W-1:0]   count,
   input  logic signed [31:0] sample,
   input  logic signed [31:0] left_val,
   input  logic               left_gt,
   input  logic signed [31:0] right_val,
   output logic signed [31:0] val,
   output logic               gt
);

   logic signed [31:0] val_ff;
   logic signed [31:0] val_in;
   logic               occupied;
   logic               at_end;

   assign occupied = count > CNT_W'(INDEX);
   assign at_end   = count == CNT_W'(INDEX);
   // this cell holds a value strictly above the new sample
   assign gt       = occupied && (val_ff > sample);
   assign val      = val_ff;

   // insert: larger values move one cell up; shift: drain toward cell 0
   always_comb begin
      val_in = val_ff;
      if (ctrl.shift) begin
         val_in = right_val;
      end else if (ctrl.insert) begin
         if (left_gt) begin
            val_in = left_val;
         end else if (gt || at_end) begin
            val_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ===== sv/sscpk_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sscpk_div #(
   parameter int DW = 73,
   parameter int VW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic          done
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          take;

   // shift in the next dividend bit and try the subtraction
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign take  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], take};
         rem_ff <= take ? diff[VW-1:0] : trial[VW-1:0];
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== sv/sscpk_sqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
module sscpk_sqrt import sscpk_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ROOT_IN_W-1:0] operand,
   output logic [ROOT_W-1:0]    root,
   output logic                 done
);

   logic [ROOT_IN_W-1:0] v_ff;
   logic [ROOT_IN_W-1:0] res_ff;
   logic [ROOT_IN_W-1:0] bit_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [ROOT_IN_W-1:0] trial;
   logic                 take;

   assign trial = res_ff + bit_ff;
   assign take  = v_ff >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // test bit walks down two places per step
   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= operand;
         res_ff <= '0;
         bit_ff <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
      end else if (busy_ff) begin
         if (take) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign root = res_ff[ROOT_W-1:0];
   assign done = done_ff;

endmodule

// ===== sv/sample_stats_cpk_engine.sv =====
// Top level: sorting cell chain, statistics sequencer and CSR block.
//
//   channel   direction  ports                          payload
//   req       in         req_valid / req_ready          req_data  (sample, last)
//   rsp       out        rsp_valid / rsp_ready          rsp_data  (count .. status)
//   csr       in/out     csr_psel/penable/pwrite/...    32-bit registers at 4*index
//
// Samples are taken one per cycle into the sorted cell chain.
// After the last sample the statistics pass runs: mean, scan, median, variance,
// square root and Cpk; its divisions use the shared one-bit-per-cycle divider
// (DIV_W = 64 + count width, 73 by default). No sample is taken during the pass.
// The result waits in an output register; a stalled rsp holds the block in
// its final state. Reset clears the set and the configuration registers.
module sample_stats_cpk_engine import sscpk_pkg::*; #(
   parameter int MAX_SAMPLES = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SCAN_W = CNT_W + 1;
   localparam int SUM_W  = 32 + CNT_W;
   localparam int ACC_W  = 64 + CNT_W;
   localparam int NUM_W  = 32 + FRAC_BITS;
   localparam int PROD_W = SUM_W + 2;
   localparam int DVS_W  = (CNT_W > 33) ? CNT_W : 33;
   localparam int DIV_W  = (ACC_W > NUM_W) ? ACC_W : NUM_W;
   localparam logic [31:0] CPK_NONE = ~((32'd1 << FRAC_BITS) - 32'd1);

   // ---------------- registers ----------------
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic                      ovf_ff;
   logic signed [31:0]        upper_ff, lower_ff;
   logic                      upper_en_ff, lower_en_ff;
   logic signed [31:0]        mean_ff, hi_ff, lo_ff, median_ff;
   logic [SCAN_W-1:0]         scan_ff;
   logic [31:0]               d_ff;
   logic                      d_vld_ff;
   logic [63:0]               sq_ff;
   logic                      sq_vld_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [PROD_W-1:0]         off_hi_ff, off_lo_ff;
   logic [30:0]               sigma_ff, cu_ff, cl_ff;
   logic [1:0]                status_ff, status_in;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;

   // ---------------- control ----------------
   logic                      accept, full, csr_wr;
   logic                      div_start, div_done, root_start, root_done;
   logic [DIV_W-1:0]          div_dividend, div_quo;
   logic [DVS_W-1:0]          div_divisor;
   logic [ROOT_W-1:0]         root_val;
   cell_ctrl_type             cell_ctrl;
   logic                      scanning, scan_end, cpk_needed, out_free;

   // ---------------- arithmetic helpers ----------------
   logic [SUM_W-1:0]          sum_mag;
   logic signed [SUM_W-1:0]   sum_neg;
   logic [31:0]               mean_q;
   logic signed [31:0]        mean_val;
   logic signed [32:0]        hd_diff, ul_diff, ll_diff;
   logic [32:0]               hd_neg, ul_neg, ll_neg;
   logic [31:0]               hd_mag, ul_mag, ll_mag;
   logic signed [CNT_W:0]     n_s;
   logic signed [PROD_W-1:0]  prod_hi, prod_lo, dif_hi, dif_lo;
   logic [PROD_W-1:0]         neg_hi, neg_lo;
   logic [DVS_W-1:0]          three_sigma;
   logic [30:0]               cpk_q, cpk_min;
   logic                      var_sat;
   logic [SCAN_W-1:0]         mid_idx;
   logic [CNT_W+8:0]          cnt_wide;

   logic signed [31:0]        cell_val [MAX_SAMPLES];
   logic                      cell_gt  [MAX_SAMPLES];

   assign accept   = req_valid && req_ready;
   assign full     = cnt_ff == CNT_W'(MAX_SAMPLES);
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------- sorting chain ----------------
   genvar gi;
   generate
      for (gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
         logic signed [31:0] lval, rval;
         logic               lgt;
         if (gi == 0) begin : g_head
            assign lval = '0;
            assign lgt  = 1'b0;
         end else begin : g_body
            assign lval = cell_val[gi-1];
            assign lgt  = cell_gt[gi-1];
         end
         if (gi == MAX_SAMPLES - 1) begin : g_tail
            assign rval = '0;
         end else begin : g_inner
            assign rval = cell_val[gi+1];
         end
         sscpk_cell #(
            .INDEX (gi),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .count     (cnt_ff),
            .sample    (req_data.sample),
            .left_val  (lval),
            .left_gt   (lgt),
            .right_val (rval),
            .val       (cell_val[gi]),
            .gt        (cell_gt[gi])
         );
      end
   endgenerate

   // ---------------- shared units ----------------
   sscpk_div #(
      .DW (DIV_W),
      .VW (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   sscpk_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (div_quo[ROOT_IN_W-1:0]),
      .root    (root_val),
      .done    (root_done)
   );

   // ---------------- arithmetic ----------------
   assign sum_neg  = -sum_ff;
   assign sum_mag  = sum_ff[SUM_W-1] ? sum_neg : sum_ff;
   assign mean_q   = div_quo[31:0];
   assign mean_val = sum_ff[SUM_W-1] ? -$signed(mean_q) : $signed(mean_q);

   // |head - mean| for the variance pass
   assign hd_diff = 33'(cell_val[0]) - 33'(mean_ff);
   assign hd_neg  = -hd_diff;
   assign hd_mag  = hd_diff[32] ? hd_neg[31:0] : hd_diff[31:0];

   // |limit - mean| for Cpk
   assign ul_diff = 33'(upper_ff) - 33'(mean_ff);
   assign ul_neg  = -ul_diff;
   assign ul_mag  = ul_diff[32] ? ul_neg[31:0] : ul_diff[31:0];
   assign ll_diff = 33'(lower_ff) - 33'(mean_ff);
   assign ll_neg  = -ll_diff;
   assign ll_mag  = ll_diff[32] ? ll_neg[31:0] : ll_diff[31:0];

   // distance of each middle sample from the exact mean, scaled by n
   assign n_s     = $signed({1'b0, cnt_ff});
   assign prod_hi = PROD_W'(n_s) * PROD_W'(hi_ff);
   assign prod_lo = PROD_W'(n_s) * PROD_W'(lo_ff);
   assign dif_hi  = PROD_W'(sum_ff) - prod_hi;
   assign dif_lo  = PROD_W'(sum_ff) - prod_lo;
   assign neg_hi  = -dif_hi;
   assign neg_lo  = -dif_lo;

   assign three_sigma = DVS_W'({sigma_ff, 1'b0}) + DVS_W'(sigma_ff);
   assign cpk_q   = (div_quo[DIV_W-1:31] != '0) ? SAT31 : div_quo[30:0];
   assign cpk_min = (cu_ff < cl_ff) ? cu_ff : cl_ff;
   assign var_sat = div_quo[DIV_W-1:ROOT_IN_W] != '0;

   assign mid_idx    = SCAN_W'(cnt_ff >> 1);
   assign scanning   = scan_ff < SCAN_W'(cnt_ff);
   assign scan_end   = scan_ff == (SCAN_W'(cnt_ff) + SCAN_W'(2));
   assign cpk_needed = (upper_en_ff || lower_en_ff) &&
                       (status_in == STATUS_OK || status_in == STATUS_DROP);
   assign cnt_wide   = (CNT_W + 9)'(cnt_ff);

   // status of the closed set, by precedence
   always_comb begin
      if (cnt_ff < CNT_W'(2)) begin
         status_in = STATUS_FEW;
      end else if (sigma_ff == '0) begin
         status_in = STATUS_ZERO;
      end else if (ovf_ff) begin
         status_in = STATUS_DROP;
      end else begin
         status_in = STATUS_OK;
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:      if (accept && req_data.last) state_in = S_MEAN_GO;
         S_MEAN_GO:   state_in = S_MEAN_WAIT;
         S_MEAN_WAIT: if (div_done) state_in = S_SCAN;
         S_SCAN:      if (scan_end) state_in = S_MED_MUL;
         S_MED_MUL:   state_in = S_MED_SEL;
         S_MED_SEL:   state_in = (cnt_ff < CNT_W'(2)) ? S_STAT : S_VAR_GO;
         S_VAR_GO:    state_in = S_VAR_WAIT;
         S_VAR_WAIT:  if (div_done) state_in = var_sat ? S_STAT : S_ROOT_GO;
         S_ROOT_GO:   state_in = S_ROOT_WAIT;
         S_ROOT_WAIT: if (root_done) state_in = S_STAT;
         S_STAT:      state_in = cpk_needed ? S_UP_GO : S_FINISH;
         S_UP_GO:     state_in = upper_en_ff ? S_UP_WAIT : S_LO_GO;
         S_UP_WAIT:   if (div_done) state_in = S_LO_GO;
         S_LO_GO:     state_in = lower_en_ff ? S_LO_WAIT : S_FINISH;
         S_LO_WAIT:   if (div_done) state_in = S_FINISH;
         S_FINISH:    if (out_free) state_in = S_LOAD;
         default:     state_in = S_LOAD;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_ready        = 1'b0;
      div_start        = 1'b0;
      root_start       = 1'b0;
      div_dividend     = '0;
      div_divisor      = '0;
      cell_ctrl.insert = 1'b0;
      cell_ctrl.shift  = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready        = 1'b1;
            cell_ctrl.insert = req_valid && !full;
         end
         S_MEAN_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(sum_mag + SUM_W'(cnt_ff >> 1));
            div_divisor  = DVS_W'(cnt_ff);
         end
         S_SCAN: begin
            cell_ctrl.shift = scanning;
         end
         S_VAR_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(acc_ff);
            div_divisor  = DVS_W'(cnt_ff - CNT_W'(1));
         end
         S_ROOT_GO: begin
            root_start = 1'b1;
         end
         S_UP_GO: begin
            div_start    = upper_en_ff;
            div_dividend = DIV_W'(NUM_W'(ul_mag) << FRAC_BITS);
            div_divisor  = three_sigma;
         end
         S_LO_GO: begin
            div_start    = lower_en_ff;
            div_dividend = DIV_W'(NUM_W'(ll_mag) << FRAC_BITS);
            div_divisor  = three_sigma;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         d_vld_ff     <= 1'b0;
         sq_vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         d_vld_ff  <= (state_ff == S_SCAN) && scanning;
         sq_vld_ff <= d_vld_ff;
         // result handshake
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // take a sample, or drop it once the chain is full
         if (accept) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               sum_ff <= sum_ff + SUM_W'(req_data.sample);
            end
         end
         // hand off the result and clear the set
         if (state_ff == S_FINISH && out_free) begin
            cnt_ff       <= '0;
            sum_ff       <= '0;
            ovf_ff       <= 1'b0;
         end
      end
   end

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff    <= '0;
         lower_ff    <= '0;
         upper_en_ff <= 1'b0;
         lower_en_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_UPPER_LIMIT:  upper_ff    <= csr_pwdata;
            REG_UPPER_ENABLE: upper_en_ff <= csr_pwdata[0];
            REG_LOWER_LIMIT:  lower_ff    <= csr_pwdata;
            REG_LOWER_ENABLE: lower_en_ff <= csr_pwdata[0];
            default:          upper_ff    <= upper_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_UPPER_LIMIT:  csr_prdata = upper_ff;
         REG_UPPER_ENABLE: csr_prdata = DATA_W'(upper_en_ff);
         REG_LOWER_LIMIT:  csr_prdata = lower_ff;
         REG_LOWER_ENABLE: csr_prdata = DATA_W'(lower_en_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // ---------------- statistics datapath ----------------
   always_ff @(posedge clock) begin
      // square and accumulate pipeline
      d_ff  <= hd_mag;
      sq_ff <= 64'(d_ff) * 64'(d_ff);
      if (state_ff == S_MEAN_GO) begin
         scan_ff <= '0;
         acc_ff  <= '0;
      end
      if (state_ff == S_MEAN_WAIT && div_done) begin
         mean_ff <= mean_val;
      end
      if (state_ff == S_SCAN) begin
         scan_ff <= scan_ff + SCAN_W'(1);
         if (scan_ff == mid_idx) begin
            hi_ff <= cell_val[0];
         end
         if (scan_ff + SCAN_W'(1) == mid_idx) begin
            lo_ff <= cell_val[0];
         end
         if (sq_vld_ff) begin
            acc_ff <= acc_ff + ACC_W'(sq_ff);
         end
      end
      if (state_ff == S_MED_MUL) begin
         off_hi_ff <= dif_hi[PROD_W-1] ? neg_hi : dif_hi;
         off_lo_ff <= dif_lo[PROD_W-1] ? neg_lo : dif_lo;
      end
      if (state_ff == S_MED_SEL) begin
         median_ff <= (cnt_ff[0] || off_hi_ff < off_lo_ff) ? hi_ff : lo_ff;
         sigma_ff  <= '0;
      end
      if (state_ff == S_VAR_WAIT && div_done && var_sat) begin
         sigma_ff <= SAT31;
      end
      if (state_ff == S_ROOT_WAIT && root_done) begin
         sigma_ff <= root_val[31] ? SAT31 : root_val[30:0];
      end
      if (state_ff == S_STAT) begin
         cu_ff     <= SAT31;
         cl_ff     <= SAT31;
         status_ff <= status_in;
      end
      if (state_ff == S_UP_WAIT && div_done) begin
         cu_ff <= cpk_q;
      end
      if (state_ff == S_LO_WAIT && div_done) begin
         cl_ff <= cpk_q;
      end
      // result register
      if (state_ff == S_FINISH && out_free) begin
         rsp_ff.count  <= cnt_wide[8:0];
         rsp_ff.mean   <= mean_ff;
         rsp_ff.median <= median_ff;
         rsp_ff.sigma  <= sigma_ff;
         rsp_ff.status <= status_ff;
         if (!upper_en_ff && !lower_en_ff) begin
            rsp_ff.cpk <= CPK_NONE;
         end else if (status_ff == STATUS_FEW || status_ff == STATUS_ZERO) begin
            rsp_ff.cpk <= '0;
         end else begin
            rsp_ff.cpk <= {1'b0, cpk_min};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count above capacity");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last) |=> state_ff == S_MEAN_GO)
      else $error("last item did not start the statistics pass");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("result raised outside the final state");

   a_few_sigma: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FEW) |-> rsp_data.sigma == '0)
      else $error("sigma nonzero for a short set");

endmodule

// ===== sim/tb_sample_stats_cpk_engine.sv =====
// Testbench for sample_stats_cpk_engine: directed table, then random sample sets, self-checked.
`timescale 1ns / 1ps

module tb_sample_stats_cpk_engine;
   import sscpk_pkg::*;

   localparam int      CAPACITY   = 256;
   localparam int      FRAC       = 16;
   localparam int      SET_DRAIN  = 800;      // idle wait after the last result, in clock cycles, with margin
   localparam longint  CYCLE_CAP  = 3000000;
   localparam longint  SAT_POS    = 64'd2147483647;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0]     csr_pwdata = '0;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   sample_stats_cpk_engine dut (.*);

   always #5 clock = ~clock;

   // predictor state: sorted set contents, sum, drop flag and limit registers
   longint       set_vals[$];
   longint       set_sum = 0;
   bit           set_dropped = 0;
   longint       up_limit = 0, lo_limit = 0;
   bit           up_en = 0, lo_en = 0;

   rsp_type      stats_due[$];
   int           mismatches = 0;
   int           items_sent = 0, sets_closed = 0, drop_sets = 0;
   longint       cycles = 0;
   bit           calm = 0;        // no idling on either side
   bit           rsp_hold = 0;    // long receiver hold-off

   function automatic longint unsigned root64(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned cpk_side(input longint lim, input longint mu,
                                                input longint unsigned sg);
      longint unsigned num, q;
      num = ((lim > mu) ? lim - mu : mu - lim) << FRAC;
      q = num / (3 * sg);
      return (q > SAT_POS) ? SAT_POS : q;
   endfunction

   // statistics of the set that the last sample closes; clears the set
   function automatic rsp_type close_set();
      rsp_type          r;
      int               n;
      longint           mu, med, hi, lo, d;
      longint unsigned  mag, off_hi, off_lo, sg, cu, cl;
      logic [127:0]     acc, vr;
      n = set_vals.size();
      mu = 0; med = 0; sg = 0;
      if (n > 0) begin
         mag = (set_sum < 0) ? -set_sum : set_sum;
         mu = (mag + n / 2) / n;
         if (set_sum < 0) mu = -mu;
         if (n % 2) begin
            med = set_vals[n / 2];
         end else begin
            hi = set_vals[n / 2];
            lo = set_vals[n / 2 - 1];
            off_hi = (set_sum > n * hi) ? set_sum - n * hi : n * hi - set_sum;
            off_lo = (set_sum > n * lo) ? set_sum - n * lo : n * lo - set_sum;
            med = (off_hi < off_lo) ? hi : lo;
         end
      end
      if (n >= 2) begin
         acc = '0;
         foreach (set_vals[i]) begin
            d = (set_vals[i] > mu) ? set_vals[i] - mu : mu - set_vals[i];
            acc = acc + 128'(d) * 128'(d);
         end
         vr = acc / 128'(n - 1);
         if (vr[127:64] != 0) sg = SAT_POS;
         else begin
            sg = root64(vr[63:0]);
            if (sg > SAT_POS) sg = SAT_POS;
         end
      end
      r.count  = n[8:0];
      r.mean   = mu[31:0];
      r.median = med[31:0];
      r.sigma  = sg[30:0];
      if (n < 2) r.status = STATUS_FEW;
      else if (sg == 0) r.status = STATUS_ZERO;
      else if (set_dropped) r.status = STATUS_DROP;
      else r.status = STATUS_OK;
      if (!up_en && !lo_en) r.cpk = -(32'sd1 <<< FRAC);
      else if (r.status == STATUS_OK || r.status == STATUS_DROP) begin
         cu = up_en ? cpk_side(up_limit, mu, sg) : SAT_POS;
         cl = lo_en ? cpk_side(lo_limit, mu, sg) : SAT_POS;
         r.cpk = (cu < cl) ? cu[31:0] : cl[31:0];
      end else r.cpk = '0;
      if (set_dropped) drop_sets++;
      set_vals.delete();
      set_sum = 0;
      set_dropped = 0;
      return r;
   endfunction

   // take one accepted sample into the predictor; returns 1 when it closes a set
   function automatic bit absorb(input req_type it, output rsp_type r);
      int i;
      if (set_vals.size() < CAPACITY) begin
         i = set_vals.size();
         while (i > 0 && set_vals[i - 1] > longint'(it.sample)) i--;
         set_vals.insert(i, longint'(it.sample));
         set_sum += longint'(it.sample);
      end else begin
         set_dropped = 1;
      end
      if (!it.last) return 0;
      r = close_set();
      return 1;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("ERROR t=%0t %s: got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // offer one item; a typed expectation, where given, replaces the predicted one
   task automatic send_sample(input logic signed [31:0] s, input logic lst,
                              input bit typed = 0, input rsp_type want = '0);
      rsp_type r;
      req_valid <= 1'b1;
      req_data  <= '{sample: s, last: lst};
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
      if (absorb(req_data, r)) begin
         stats_due.push_back(typed ? want : r);
         sets_closed++;
      end
      if (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (stats_due.size() != 0) @(posedge clock);
      repeat (SET_DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_UPPER_LIMIT:  up_limit = longint'($signed(v));
         REG_UPPER_ENABLE: up_en = v[0];
         REG_LOWER_LIMIT:  lo_limit = longint'($signed(v));
         REG_LOWER_ENABLE: lo_en = v[0];
      endcase
   endtask

   task automatic set_limits(input logic [31:0] ul, input bit ue,
                             input logic [31:0] ll, input bit le);
      csr_write(REG_UPPER_LIMIT, ul);
      csr_write(REG_UPPER_ENABLE, {31'd0, ue});
      csr_write(REG_LOWER_LIMIT, ll);
      csr_write(REG_LOWER_ENABLE, {31'd0, le});
   endtask

   // one random set: mostly small spread sets, some constant, some fully random, few oversized
   task automatic random_set();
      int               kind, n;
      logic [31:0]      center, spread;
      logic signed [31:0] s;
      kind = $urandom_range(0, 99);
      center = $urandom_range(0, 1) ? 32'($signed($urandom_range(0, 400)) - 200) << FRAC
                                    : $urandom;
      spread = 32'd1 << $urandom_range(0, 22);
      if (kind < 2) n = $urandom_range(CAPACITY - 2, CAPACITY + 12);
      else n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
         if (kind < 10) s = center;
         else if (kind < 30) s = $urandom;
         else s = center + $urandom_range(0, spread) - (spread >> 1);
         send_sample(s, i == n - 1);
      end
   endtask

   typedef struct {
      logic signed [31:0] s;
      logic               lst;
      bit                 typed;
      rsp_type            want;
   } row_type;

   localparam logic signed [31:0] SMIN = 32'sh8000_0000;
   localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] NO_CPK = -(32'sd1 <<< FRAC);

   row_type directed[] = '{
      '{SMIN, 1'b1, 1, '{9'd1, SMIN, SMIN, 31'd0, NO_CPK, STATUS_FEW}},
      '{SMAX, 1'b1, 1, '{9'd1, SMAX, SMAX, 31'd0, NO_CPK, STATUS_FEW}},
      '{32'sd5, 1'b0, 0, '0},
      '{32'sd5, 1'b1, 1, '{9'd2, 32'sd5, 32'sd5, 31'd0, NO_CPK, STATUS_ZERO}},
      '{SMIN, 1'b0, 0, '0},
      '{SMAX, 1'b1, 0, '0},
      '{32'sd0, 1'b0, 0, '0},
      '{32'sd30, 1'b0, 0, '0},
      '{32'sd10, 1'b0, 0, '0},
      '{32'sd20, 1'b1, 0, '0},
      '{32'sd9, 1'b0, 0, '0},
      '{32'sd1, 1'b0, 0, '0},
      '{32'sd7, 1'b0, 0, '0},
      '{32'sd3, 1'b1, 0, '0},
      '{-32'sd65536, 1'b0, 0, '0},
      '{32'sd131072, 1'b0, 0, '0},
      '{32'sd65536, 1'b1, 0, '0}
   };

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (stats_due.size() == 0) begin
            report("unexpected result count", rsp_data.count, -1);
         end else begin
            want = stats_due.pop_front();
            if (rsp_data.count != want.count) report("count", rsp_data.count, want.count);
            if (rsp_data.mean != want.mean) report("mean", rsp_data.mean, want.mean);
            if (rsp_data.median != want.median)
               report("median", rsp_data.median, want.median);
            if (rsp_data.sigma != want.sigma) report("sigma", rsp_data.sigma, want.sigma);
            if (rsp_data.cpk != want.cpk) report("cpk", rsp_data.cpk, want.cpk);
            if (rsp_data.status != want.status)
               report("status", rsp_data.status, want.status);
         end
      end
   end

   // receiver: random stalls except when calm, held off entirely during pressure
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && (calm || $urandom_range(0, 99) >= 15);
   end

   // pressure: once the run is underway, block the result side for a long stretch
   initial begin
      wait (items_sent >= 700);
      @(posedge clock);
      rsp_hold = 1;
      repeat (4000) @(posedge clock);
      rsp_hold = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_sample(directed[i].s, directed[i].lst, directed[i].typed, directed[i].want);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_limits(32'd100 << FRAC, 1, -(32'sd100 <<< FRAC), 1);
            1: set_limits(SMAX, 1, 32'd0, 0);
            2: set_limits(32'hdead_beef, 0, SMIN, 1);
            3: set_limits($urandom, 1, $urandom, 1);
            4: set_limits(SMIN, 1, SMAX, 1);
            default: set_limits(32'd0, 0, 32'd0, 0);
         endcase
         calm = (ph == 2);
         while (items_sent < 17 + (ph + 1) * 215) random_set();
         wait_idle();
      end

      $display("Covered %0d samples in %0d sets (%0d with dropped samples),",
               items_sent, sets_closed, drop_sets);
      $display("six limit settings including extremes, a long result stall and no-idle stretch.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
